FILE: sv/sba_pkg.sv
// shared constants, codes and types of the slot bitmap allocator
package sba_pkg;

  localparam int MAX_SLOTS_DEF  = 4096;
  localparam int WORD_BITS_DEF  = 64;
  localparam int CFG_W          = 13;
  localparam int IDX_W          = 12;
  localparam int KIND_W         = 3;
  localparam int STAT_W         = 3;
  localparam int POS_W          = 6;
  localparam int SLOT_COUNT_RST = 4096;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_CLR_ALL   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SET       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLR       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TEST      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FIND_FREE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FIND_USED = 3'd5;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 3'd1;
  localparam logic [STAT_W-1:0] STAT_SET   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_CLEAR = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL  = 3'd4;
  localparam logic [STAT_W-1:0] STAT_NONE  = 3'd5;

  // what the word unit tells the sequencer about one map word
  typedef struct packed {
    logic             hit;      // a candidate bit in range
    logic [POS_W-1:0] pos;      // lowest candidate bit
    logic             in_word;  // the target slot lies in this word
    logic [POS_W-1:0] sel_off;  // bit offset of the target slot
    logic             sel_bit;  // value of the target slot
    logic             last;     // word reaches the slot limit
  } wu_res_t;

endpackage

FILE: sv/sba_map_mem.sv
// occupancy map memory with per-word valid bits and registered read
module sba_map_mem import sba_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int MAP_WORDS = MAX_SLOTS_DEF / WORD_BITS_DEF,
  parameter int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clr_all,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic [ADDR_W-1:0]    raddr,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem_r [0:MAP_WORDS-1];
  logic [MAP_WORDS-1:0] vld_r;
  logic [WORD_BITS-1:0] rd_word_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[raddr];
      if (clr_all) begin
        vld_r <= '0;
      end else if (we) begin
        vld_r[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_word_r <= mem_r[raddr];
  end

  // a word never written since reset or clear reads as empty
  assign rdata = rd_vld_r ? rd_word_r : '0;

endmodule

FILE: sv/sba_word_unit.sv
// shared word unit: range mask, priority encoder and bit pick over one map word
module sba_word_unit import sba_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int CMP_W     = CFG_W
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic                 invert,
  input  logic [CMP_W-1:0]     base,
  input  logic [CMP_W-1:0]     lo,
  input  logic [CMP_W-1:0]     hi,
  output wu_res_t              res
);

  localparam int OFF_W = $clog2(WORD_BITS + 1);
  localparam int REL_W = CMP_W + 1;
  localparam logic signed [REL_W-1:0] WB_S = REL_W'(WORD_BITS);

  logic signed [REL_W-1:0] rel_lo;
  logic signed [REL_W-1:0] rel_hi;
  logic [OFF_W-1:0]        lo_c;
  logic [OFF_W-1:0]        hi_c;
  logic [WORD_BITS-1:0]    src;
  logic [WORD_BITS-1:0]    cand;

  always_comb begin
    rel_lo = $signed({1'b0, lo}) - $signed({1'b0, base});
    rel_hi = $signed({1'b0, hi}) - $signed({1'b0, base});
    if (rel_lo < 0) begin
      lo_c = '0;
    end else if (rel_lo > WB_S) begin
      lo_c = OFF_W'(WORD_BITS);
    end else begin
      lo_c = rel_lo[OFF_W-1:0];
    end
    if (rel_hi < 0) begin
      hi_c = '0;
    end else if (rel_hi > WB_S) begin
      hi_c = OFF_W'(WORD_BITS);
    end else begin
      hi_c = rel_hi[OFF_W-1:0];
    end
  end

  always_comb begin
    src = invert ? ~word : word;
    for (int j = 0; j < WORD_BITS; j++) begin
      cand[j] = src[j] && (OFF_W'(j) >= lo_c) && (OFF_W'(j) < hi_c);
    end
  end

  always_comb begin
    res = '0;
    res.hit = |cand;
    // lowest set bit wins
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        res.pos = POS_W'(j);
      end
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      if (lo_c == OFF_W'(j)) begin
        res.sel_bit = word[j];
      end
    end
    res.sel_off = POS_W'(lo_c);
    res.in_word = (rel_lo >= 0) && (rel_lo < WB_S);
    res.last    = (rel_hi <= WB_S);
  end

endmodule

FILE: sv/slot_bitmap_allocator.sv
// slot bitmap allocator top level: request sequencer, config register and result register
//
// Keeps a bitmap of record slots and answers one result beat per request beat.
// Request beats come in on in_*: in_tuser carries the request kind, in_tdata
// the slot index. Result beats leave on out_*: status, found slot, occupied.
// cfg_wr_en with cfg_wr_data sets slot_count; write it only while idle.
// Every request except clear-all, unused kinds and rejected indices walks the
// map from word 0, one WORD_BITS-wide word per cycle through a single mask and
// priority-encode unit behind a registered-read memory. A request whose slot
// or hit lies in word w raises out_tvalid after word w is read, examined and
// passed through S_DONE into the output register, and in_tready comes back in
// that same cycle; a failed search ends at the word that reaches the limit.
// Clear-all, unused kinds and rejected requests go from idle to S_DONE at once.
// One request is handled at a time: in_tready is high only while idle.
// A finished result waits in a holding register until the output register is
// free, so a stalled receiver holds back the next request only after one beat.
// Reset empties the map at once through per-word valid bits (no clearing
// pass), sets slot_count to 4096 and drops out_tvalid.
module slot_bitmap_allocator import sba_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,  // slot_count
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [15:0]      in_tdata,     // slot_index [11:0], zero [15:12]
  input  logic [2:0]       in_tuser,     // kind [2:0]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata     // status [2:0], found_slot [14:3], occupied [15]
);

  localparam int MAP_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int LIM_W     = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W     = (LIM_W > CFG_W) ? LIM_W : CFG_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    slot_count_r;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [CMP_W-1:0]    idx_r, idx_nxt;
  logic [ADDR_W-1:0]   rd_addr_r, rd_addr_nxt;
  logic [ADDR_W-1:0]   ev_addr_r, ev_addr_nxt;
  logic [CMP_W-1:0]    ev_base_r, ev_base_nxt;
  logic                pend_r, pend_nxt;
  logic [STAT_W-1:0]   res_status_r, res_status_nxt;
  logic [CMP_W-1:0]    res_found_r, res_found_nxt;
  logic                res_occ_r, res_occ_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [IDX_W-1:0]    out_found_r, out_found_nxt;
  logic                out_occ_r, out_occ_nxt;

  logic [CMP_W-1:0]     cnt_ext;
  logic [CMP_W-1:0]     lim;
  logic [CMP_W-1:0]     in_idx;
  logic                 mem_we;
  logic                 clr_all;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] wdata;
  logic [CMP_W-1:0]     wu_lo;
  wu_res_t              wu_res;

  assign cnt_ext = CMP_W'(slot_count_r);
  assign lim     = (cnt_ext < CMP_W'(MAX_SLOTS)) ? cnt_ext : CMP_W'(MAX_SLOTS);
  assign in_idx  = CMP_W'(in_tdata[IDX_W-1:0]);
  assign wu_lo   = (kind_r == KIND_FIND_FREE) ? '0 : idx_r;
  // set only hits a clear bit and clear only a set one, so a toggle does both
  assign wdata   = rdata ^ (WORD_BITS'(1) << wu_res.sel_off);

  sba_map_mem #(
    .WORD_BITS (WORD_BITS),
    .MAP_WORDS (MAP_WORDS),
    .ADDR_W    (ADDR_W)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr_all (clr_all),
    .we      (mem_we),
    .waddr   (ev_addr_r),
    .wdata   (wdata),
    .raddr   (rd_addr_r),
    .rdata   (rdata)
  );

  sba_word_unit #(
    .WORD_BITS (WORD_BITS),
    .CMP_W     (CMP_W)
  ) u_word (
    .word   (rdata),
    .invert (kind_r == KIND_FIND_FREE),
    .base   (ev_base_r),
    .lo     (wu_lo),
    .hi     (lim),
    .res    (wu_res)
  );

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    idx_nxt        = idx_r;
    rd_addr_nxt    = rd_addr_r;
    ev_addr_nxt    = ev_addr_r;
    ev_base_nxt    = ev_base_r;
    pend_nxt       = pend_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_occ_nxt    = res_occ_r;
    out_vld_nxt    = out_vld_r && !out_tready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_occ_nxt    = out_occ_r;
    mem_we         = 1'b0;
    clr_all        = 1'b0;
    in_tready      = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt       = in_tuser;
          idx_nxt        = in_idx;
          rd_addr_nxt    = '0;
          pend_nxt       = 1'b0;
          res_status_nxt = STAT_OK;
          res_found_nxt  = '0;
          res_occ_nxt    = 1'b0;
          state_nxt      = S_SCAN;
          case (in_tuser) inside
            KIND_CLR_ALL: begin
              clr_all   = 1'b1;
              state_nxt = S_DONE;
            end
            KIND_SET, KIND_CLR, KIND_TEST: begin
              if (in_idx >= lim) begin
                res_status_nxt = STAT_RANGE;
                state_nxt      = S_DONE;
              end
            end
            KIND_FIND_FREE: begin
              if (lim == '0) begin
                res_status_nxt = STAT_FULL;
                state_nxt      = S_DONE;
              end
            end
            KIND_FIND_USED: begin
              if (in_idx >= lim) begin
                res_status_nxt = STAT_NONE;
                state_nxt      = S_DONE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        // next read goes out while the previous word is examined
        rd_addr_nxt = (rd_addr_r == ADDR_W'(MAP_WORDS - 1)) ? rd_addr_r : rd_addr_r + 1'b1;
        ev_addr_nxt = rd_addr_r;
        pend_nxt    = 1'b1;
        ev_base_nxt = pend_r ? ev_base_r + CMP_W'(WORD_BITS) : '0;
        if (pend_r) begin
          case (kind_r) inside
            KIND_SET, KIND_CLR, KIND_TEST: begin
              if (wu_res.in_word) begin
                state_nxt = S_DONE;
                if (kind_r == KIND_TEST) begin
                  res_occ_nxt = wu_res.sel_bit;
                end else if (kind_r == KIND_SET) begin
                  if (wu_res.sel_bit) begin
                    res_status_nxt = STAT_SET;
                  end else begin
                    mem_we = 1'b1;
                  end
                end else begin
                  if (!wu_res.sel_bit) begin
                    res_status_nxt = STAT_CLEAR;
                  end else begin
                    mem_we = 1'b1;
                  end
                end
              end
            end
            KIND_FIND_FREE, KIND_FIND_USED: begin
              if (wu_res.hit) begin
                res_found_nxt = ev_base_r + CMP_W'(wu_res.pos);
                state_nxt     = S_DONE;
              end else if (wu_res.last) begin
                res_status_nxt = (kind_r == KIND_FIND_FREE) ? STAT_FULL : STAT_NONE;
                state_nxt      = S_DONE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt    = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r[IDX_W-1:0];
          out_occ_nxt    = res_occ_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_count_r <= CFG_W'(SLOT_COUNT_RST);
      pend_r       <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pend_r    <= pend_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_wr_en) begin
        slot_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    idx_r        <= idx_nxt;
    rd_addr_r    <= rd_addr_nxt;
    ev_addr_r    <= ev_addr_nxt;
    ev_base_r    <= ev_base_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_occ_r    <= res_occ_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_occ_r, out_found_r, out_status_r};

  a_we_on_target: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_SCAN) && pend_r && wu_res.in_word)
    else $error("map write outside target word");

  a_base_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && pend_r |-> ev_base_r < lim)
    else $error("scan ran past slot limit");

  a_found_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && (res_status_r == STAT_OK) &&
    ((kind_r == KIND_FIND_FREE) || (kind_r == KIND_FIND_USED)) |-> res_found_r < lim)
    else $error("search reported slot beyond limit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> (state_r != S_IDLE))
    else $error("sequencer idle after request beat");

endmodule
